// ===== rtl/core/n2i_pkg.sv =====
// n2i_pkg: shared types, constants and helpers for the NV12 to I420 crop unit.
// Used by every module under rtl/core; depends on nothing else.
package n2i_pkg;

  // Register and field widths
  localparam int DimW   = 13;
  localparam int CntW   = 12;
  localparam int AddrW  = 25;
  localparam int ByteW  = 8;
  localparam int PaddrW = 4;

  // Geometry limits
  localparam logic [DimW-1:0] MaxWidth  = DimW'(4096);
  localparam logic [DimW-1:0] MaxHeight = DimW'(4096);
  localparam logic [DimW-1:0] MinDim    = DimW'(2);

  // Register reset values
  localparam logic [DimW-1:0] RstCodedW = DimW'(1920);
  localparam logic [DimW-1:0] RstCodedH = DimW'(1088);
  localparam logic [DimW-1:0] RstVisW   = DimW'(1920);
  localparam logic [DimW-1:0] RstVisH   = DimW'(1080);

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_CODED_W = 2'd0,
    REG_CODED_H = 2'd1,
    REG_VIS_W   = 2'd2,
    REG_VIS_H   = 2'd3
  } reg_idx_t;

  // Clamped frame geometry
  typedef struct packed {
    logic [DimW-1:0] cw;
    logic [DimW-1:0] ch;
    logic [DimW-1:0] vw;
    logic [DimW-1:0] vh;
  } geom_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic             has_byte;
    logic             chroma;
    logic             odd;
    logic [AddrW-1:0] partial;
    logic [ByteW-1:0] data;
    logic             done;
    logic             short_fr;
  } item_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    r = v;
    if (v < MinDim) r = MinDim;
    if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [DimW-1:0] min_dim(input logic [DimW-1:0] a,
                                              input logic [DimW-1:0] b);
    return (a > b) ? b : a;
  endfunction

endpackage

// ===== rtl/core/n2i_front.sv =====
// n2i_front: accepts bytes, tracks plane/row/column, classifies each byte.
// Depends on n2i_pkg.
module n2i_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  n2i_pkg::geom_t         geom,
  input  logic                   accept,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output logic                   q_push,
  output n2i_pkg::item_t         q_item
);
  import n2i_pkg::*;

  logic [CntW-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic             chroma_r, chroma_nxt, past_r, past_nxt;
  logic [AddrW-1:0] lrb_r, lrb_nxt, crb_r, crb_nxt;

  logic [CntW-1:0]  hw, hh, full, tail;
  logic [DimW-1:0]  col_inc, row_inc;
  logic             luma_hit, chroma_hit, kept;
  logic [AddrW-1:0] partial;
  logic             past_step;

  // Classification from current position
  always_comb begin
    hw = geom.vw[DimW-1:1];
    hh = geom.vh[DimW-1:1];
    full = geom.ch[DimW-1:1];
    tail = geom.ch[0] ? geom.cw[DimW-1:1] : '0;
    luma_hit = !chroma_r && ({1'b0, row_r} < geom.vh) && ({1'b0, col_r} < geom.vw);
    chroma_hit = chroma_r && (row_r < hh) && ({1'b0, col_r} < {hw, 1'b0});
    kept = !past_r && (luma_hit || chroma_hit);
    partial = chroma_r ? crb_r + {{(AddrW-CntW+1){1'b0}}, col_r[CntW-1:1]}
                       : lrb_r + {{(AddrW-CntW){1'b0}}, col_r};
  end

  // Position update
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    chroma_nxt = chroma_r;
    past_nxt = past_r;
    lrb_nxt = lrb_r;
    crb_nxt = crb_r;
    col_inc = {1'b0, col_r} + DimW'(1);
    row_inc = {1'b0, row_r} + DimW'(1);
    if (!past_r) begin
      col_nxt = col_inc[CntW-1:0];
      if (col_inc >= geom.cw) begin
        col_nxt = '0;
        row_nxt = row_inc[CntW-1:0];
        if (!chroma_r) begin
          lrb_nxt = lrb_r + {{(AddrW-DimW){1'b0}}, geom.vw};
          if (row_inc >= geom.ch) begin
            chroma_nxt = 1'b1;
            row_nxt = '0;
          end
        end else begin
          crb_nxt = crb_r + {{(AddrW-CntW){1'b0}}, hw};
        end
      end
      if (chroma_nxt && ((row_nxt > full) || ((row_nxt == full) && (col_nxt >= tail)))) begin
        past_nxt = 1'b1;
      end
    end
    // past_end after this byte, before the frame-end clear
    past_step = past_nxt;
    // Frame end: back to the start of the next frame
    if (in_last) begin
      col_nxt = '0;
      row_nxt = '0;
      chroma_nxt = 1'b0;
      past_nxt = 1'b0;
      lrb_nxt = '0;
      crb_nxt = '0;
    end
  end

  // Item handed to the queue
  always_comb begin
    q_push = accept && (kept || in_last);
    q_item.has_byte = kept;
    q_item.chroma = kept && chroma_r;
    q_item.odd = kept && chroma_r && col_r[0];
    q_item.partial = kept ? partial : '0;
    q_item.data = kept ? in_byte : '0;
    q_item.done = in_last;
    q_item.short_fr = in_last && !past_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      chroma_r <= 1'b0;
      past_r <= 1'b0;
      lrb_r <= '0;
      crb_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      chroma_r <= chroma_nxt;
      past_r <= past_nxt;
      lrb_r <= lrb_nxt;
      crb_r <= crb_nxt;
    end
  end

endmodule

// ===== rtl/core/n2i_queue.sv =====
// n2i_queue: short queue of classified items between front and back.
// Depends on n2i_pkg.
module n2i_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  n2i_pkg::item_t wr_item,
  input  logic           rd_en,
  output n2i_pkg::item_t rd_item,
  output logic           q_full,
  output logic           q_empty
);
  import n2i_pkg::*;

  item_t            mem [QDepth];
  logic [QPtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  // Pointer and fill count
  always_comb begin
    do_wr = wr_en && !q_full;
    do_rd = rd_en && !q_empty;
    wp_nxt = do_wr ? wp_r + QPtrW'(1) : wp_r;
    rp_nxt = do_rd ? rp_r + QPtrW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + (QPtrW+1)'(1);
    if (do_rd && !do_wr) cnt_nxt = cnt_r - (QPtrW+1)'(1);
  end

  assign q_full  = (cnt_r == (QPtrW+1)'(QDepth));
  assign q_empty = (cnt_r == '0);
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_item;
  end

endmodule

// ===== rtl/core/n2i_back.sv =====
// n2i_back: forms the I420 address and holds the result register.
// Depends on n2i_pkg.
module n2i_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  n2i_pkg::geom_t              geom,
  input  logic                        q_empty,
  input  n2i_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic                        out_has_byte,
  output logic [n2i_pkg::AddrW-1:0]   out_address,
  output logic [7:0]                  out_byte,
  output logic                        out_frame_done,
  output logic                        out_short_frame
);
  import n2i_pkg::*;

  logic [AddrW-1:0] ybase_r, csize_r, addr;
  logic [2*DimW-1:0] yprod;
  logic [2*CntW-1:0] cprod;
  logic             valid_r;
  item_t            res_r;
  logic [AddrW-1:0] addr_r;

  // Plane sizes, refreshed every cycle from the geometry
  always_comb begin
    yprod = geom.vw * geom.vh;
    cprod = geom.vw[DimW-1:1] * geom.vh[DimW-1:1];
  end

  always_ff @(posedge clk) begin
    ybase_r <= yprod[AddrW-1:0];
    csize_r <= {{(AddrW-2*CntW){1'b0}}, cprod};
  end

  // Final address: row offset plus plane base
  always_comb begin
    addr = q_item.partial + (q_item.chroma ? ybase_r : '0) + (q_item.odd ? csize_r : '0);
    q_pop = !q_empty && (!valid_r || pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_item;
      addr_r <= addr;
    end
  end

  assign empty           = !valid_r;
  assign out_has_byte    = res_r.has_byte;
  assign out_address     = addr_r;
  assign out_byte        = res_r.data;
  assign out_frame_done  = res_r.done;
  assign out_short_frame = res_r.short_fr;

endmodule

// ===== rtl/core/nv12_to_i420_crop_unit.sv =====
// Channel    | Ports                                    | Transfer when
// input      | in_byte, in_last, push, full             | push && !full
// result     | out_has_byte .. out_short_frame, pop     | pop && !empty
// config     | psel, penable, pwrite, paddr, pwdata     | psel && penable && pwrite
//
// One byte per cycle in steady state while full is low; the front position counters
// update on every accepted byte. With queue and result register empty, a result passes
// through a queue entry and then the result register on its way to the output ports.
// A four-entry queue separates classification from address forming, so a stalled
// pop fills the queue before full rises. Reset (rst_n low, synchronous) clears
// position state and loads default geometry 1920x1088, visible 1920x1080.
//
// Top level: config registers, front, queue, back. Depends on n2i_pkg and the
// n2i_front, n2i_queue and n2i_back modules.
module nv12_to_i420_crop_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last,
  input  logic                         push,
  output logic                         full,
  output logic                         out_has_byte,
  output logic [n2i_pkg::AddrW-1:0]    out_address,
  output logic [7:0]                   out_byte,
  output logic                         out_frame_done,
  output logic                         out_short_frame,
  output logic                         empty,
  input  logic                         pop,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [n2i_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import n2i_pkg::*;

  logic [DimW-1:0] cw_r, ch_r, vw_r, vh_r;
  logic            wr_en;
  reg_idx_t        idx;
  geom_t           geom;
  logic            accept, q_push, q_pop, q_full, q_empty;
  item_t           f_item, b_item;

  // Configuration registers
  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[PaddrW-1:2]);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= RstCodedW;
      ch_r <= RstCodedH;
      vw_r <= RstVisW;
      vh_r <= RstVisH;
    end else if (wr_en) begin
      unique case (idx)
        REG_CODED_W: cw_r <= pwdata[DimW-1:0];
        REG_CODED_H: ch_r <= pwdata[DimW-1:0];
        REG_VIS_W:   vw_r <= pwdata[DimW-1:0];
        REG_VIS_H:   vh_r <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CODED_W: prdata = {{(32-DimW){1'b0}}, cw_r};
      REG_CODED_H: prdata = {{(32-DimW){1'b0}}, ch_r};
      REG_VIS_W:   prdata = {{(32-DimW){1'b0}}, vw_r};
      REG_VIS_H:   prdata = {{(32-DimW){1'b0}}, vh_r};
      default:     prdata = '0;
    endcase
  end

  // Clamped geometry
  always_comb begin
    geom.cw = clamp_dim(cw_r, MaxWidth);
    geom.ch = clamp_dim(ch_r, MaxHeight);
    geom.vw = min_dim(vw_r, geom.cw);
    geom.vh = min_dim(vh_r, geom.ch);
  end

  assign full = q_full;
  assign accept = push && !q_full;

  n2i_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_push  (q_push),
    .q_item  (f_item)
  );

  n2i_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (f_item),
    .rd_en   (q_pop),
    .rd_item (b_item),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  n2i_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .geom            (geom),
    .q_empty         (q_empty),
    .q_item          (b_item),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_has_byte    (out_has_byte),
    .out_address     (out_address),
    .out_byte        (out_byte),
    .out_frame_done  (out_frame_done),
    .out_short_frame (out_short_frame)
  );

endmodule

// ===== rtl/core/n2i_checker.sv =====
// n2i_checker: port-level checks for nv12_to_i420_crop_unit, bound to the top level.
// Depends on n2i_pkg for the address width.
module n2i_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       empty,
  input logic                       pop,
  input logic                       out_has_byte,
  input logic [n2i_pkg::AddrW-1:0]  out_address,
  input logic [7:0]                 out_byte,
  input logic                       out_frame_done,
  input logic                       out_short_frame
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  // A short frame is only flagged on the frame's last result
  a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_short_frame |-> out_frame_done)
    else $error("short_frame without frame_done");

  // A result without a byte exists only to end a frame, with zeroed payload
  a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_has_byte |-> out_frame_done && (out_address == '0) && (out_byte == '0))
    else $error("empty result that does not end a frame");

  // A waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_address) && $stable(out_byte))
    else $error("result changed while stalled");

endmodule

bind nv12_to_i420_crop_unit n2i_checker u_n2i_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_has_byte    (out_has_byte),
  .out_address     (out_address),
  .out_byte        (out_byte),
  .out_frame_done  (out_frame_done),
  .out_short_frame (out_short_frame)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for nv12_to_i420_crop_unit with queue-style in/out and APB setup.
// Needs n2i_pkg and the RTL under rtl/core; a local frame tracker predicts every I420 write.
module tb;
  import n2i_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } nv12_byte_t;

  typedef struct {
    logic             has_byte;
    logic [AddrW-1:0] address;
    logic [7:0]       data;
    logic             frame_done;
    logic             short_frame;
  } i420_write_t;

  localparam int SettleCycles = 12;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic [7:0]       in_byte = '0;
  logic             in_last = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic             out_has_byte;
  logic [AddrW-1:0] out_address;
  logic [7:0]       out_byte;
  logic             out_frame_done;
  logic             out_short_frame;
  logic             empty;
  logic             pop = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  nv12_to_i420_crop_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_byte(in_byte), .in_last(in_last), .push(push), .full(full),
    .out_has_byte(out_has_byte), .out_address(out_address), .out_byte(out_byte),
    .out_frame_done(out_frame_done), .out_short_frame(out_short_frame),
    .empty(empty), .pop(pop),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Bytes waiting to be sent and I420 writes waiting to be seen
  nv12_byte_t  nv12_bytes_q[$];
  i420_write_t i420_writes_q[$];
  int          mismatches = 0;
  int          idle_odds = 0;

  // Geometry registers as last written, and the frame position
  logic [DimW-1:0] geo_cw = 13'd1920, geo_ch = 13'd1088, geo_vw = 13'd1920, geo_vh = 13'd1080;
  int unsigned pos_col = 0, pos_row = 0, luma_base = 0, chroma_base = 0;
  logic        pos_chroma = 1'b0, pos_past_end = 1'b0;

  function automatic int unsigned clamp_span(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Bytes in one complete coded frame under the current geometry
  function automatic int unsigned coded_bytes();
    int unsigned cw, ch;
    cw = clamp_span(geo_cw, 2, 4096);
    ch = clamp_span(geo_ch, 2, 4096);
    return cw * ch * 3 / 2;
  endfunction

  // Advance the frame position by one byte and queue the I420 write it causes
  function void track_nv12_byte(input logic [7:0] b, input logic lst);
    int unsigned cw, ch, vw, vh, hw, hh, addr, base, full_rows, tail;
    logic        kept, done, short_fr;
    i420_write_t w;
    cw = clamp_span(geo_cw, 2, 4096);
    ch = clamp_span(geo_ch, 2, 4096);
    vw = (geo_vw > cw) ? cw : geo_vw;
    vh = (geo_vh > ch) ? ch : geo_vh;
    hw = vw >> 1;
    hh = vh >> 1;
    kept = 1'b0;
    addr = 0;
    done = 1'b0;
    short_fr = 1'b0;
    if (!pos_past_end) begin
      if (!pos_chroma) begin
        if (pos_row < vh && pos_col < vw) begin
          kept = 1'b1;
          addr = luma_base + pos_col;
        end
      end else if (pos_row < hh && pos_col < 2 * hw) begin
        base = vw * vh;
        if (pos_col[0]) base += hw * hh;
        kept = 1'b1;
        addr = base + chroma_base + (pos_col >> 1);
      end
      pos_col++;
      if (pos_col >= cw) begin
        pos_col = 0;
        pos_row++;
        if (!pos_chroma) luma_base = (luma_base + vw) & 32'h1FF_FFFF;
        else chroma_base = (chroma_base + hw) & 32'h1FF_FFFF;
        if (!pos_chroma && pos_row >= ch) begin
          pos_chroma = 1'b1;
          pos_row = 0;
        end
      end
      if (pos_chroma) begin
        full_rows = ch >> 1;
        tail = ch[0] ? (cw >> 1) : 0;
        if (pos_row > full_rows || (pos_row == full_rows && pos_col >= tail))
          pos_past_end = 1'b1;
      end
    end
    if (lst) begin
      done = 1'b1;
      short_fr = !pos_past_end;
      pos_col = 0;
      pos_row = 0;
      pos_chroma = 1'b0;
      pos_past_end = 1'b0;
      luma_base = 0;
      chroma_base = 0;
    end
    if (kept || done) begin
      w.has_byte = kept;
      w.address = kept ? addr[AddrW-1:0] : '0;
      w.data = kept ? b : 8'd0;
      w.frame_done = done;
      w.short_frame = short_fr;
      i420_writes_q.push_back(w);
    end
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Sender: takes the next byte off the queue, holds it while full, idles in bursts
  int in_gap = 0;
  always @(posedge clk) begin
    nv12_byte_t nb;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) track_nv12_byte(in_byte, in_last);
      if (!(push && full)) begin
        if (in_gap > 0) begin
          in_gap--;
          push <= 1'b0;
        end else if (nv12_bytes_q.size() != 0) begin
          nb = nv12_bytes_q.pop_front();
          in_byte <= nb.data;
          in_last <= nb.last;
          push <= 1'b1;
          if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            in_gap = $urandom_range(1, 11);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest expected write
  int out_gap = 0;
  always @(posedge clk) begin
    i420_write_t w;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (i420_writes_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got addr %0d byte %0d done %0b",
                   $time, out_address, out_byte, out_frame_done);
          mismatches++;
        end else begin
          w = i420_writes_q.pop_front();
          check_field("has_byte", w.has_byte, out_has_byte);
          check_field("address", w.address, out_address);
          check_field("byte", w.data, out_byte);
          check_field("frame_done", w.frame_done, out_frame_done);
          check_field("short_frame", w.short_frame, out_short_frame);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
          out_gap = $urandom_range(1, 11);
      end
    end
  end

  // Sender holds off until everything sent has been seen and the pipe is empty
  task automatic settle();
    int guard;
    guard = 0;
    while ((nv12_bytes_q.size() != 0 || push || i420_writes_q.size() != 0) && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Setup and access cycle of one APB register write; junk above bit 12
  task automatic write_reg(input reg_idx_t idx, input logic [DimW-1:0] val);
    logic [31:0] junk;
    junk = $urandom();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk[31:DimW], val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CODED_W: geo_cw = val;
      REG_CODED_H: geo_ch = val;
      REG_VIS_W:   geo_vw = val;
      REG_VIS_H:   geo_vh = val;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic queue_bytes(input int len, input bit close_frame, inout int sent);
    nv12_byte_t nb;
    for (int i = 0; i < len; i++) begin
      nb.data = 8'($urandom_range(0, 255));
      nb.last = close_frame && (i == len - 1);
      nv12_bytes_q.push_back(nb);
    end
    sent += len;
  endtask

  function automatic logic [DimW-1:0] pick_coded();
    case ($urandom_range(0, 15))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return DimW'($urandom_range(0, 8191));
      default: return DimW'($urandom_range(2, 10));
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_visible(input int unsigned coded);
    case ($urandom_range(0, 11))
      0: return 13'd0;
      1: return 13'd8191;
      2: return 13'd4096;
      3: return DimW'(coded + $urandom_range(0, 3));
      default: return DimW'($urandom_range(0, coded));
    endcase
  endfunction

  // Main sequence
  initial begin
    nv12_byte_t  nb;
    int          sent, n, len;
    int unsigned ecw, ech;
    bit          first;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default geometry: byte extremes, then a frame cut short
    nb.last = 1'b0;
    nb.data = 8'h00; nv12_bytes_q.push_back(nb);
    nb.data = 8'hFF; nv12_bytes_q.push_back(nb);
    nb.data = 8'hA5; nv12_bytes_q.push_back(nb);
    nb.data = 8'h5A; nv12_bytes_q.push_back(nb);
    nb.data = 8'h7E; nb.last = 1'b1; nv12_bytes_q.push_back(nb);
    settle();

    // 4x3 coded, odd height: luma, U, V, partial chroma tail, bytes past the end
    write_reg(REG_CODED_W, 13'd4);
    write_reg(REG_CODED_H, 13'd3);
    write_reg(REG_VIS_W, 13'd4);
    write_reg(REG_VIS_H, 13'd3);
    queue_bytes(20, 1'b0, sent);
    queue_bytes(1, 1'b1, sent);

    // Random geometry phases; a frame may stay open across a register change
    first = 1'b1;
    while (sent < 1220) begin
      settle();
      idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if (first || $urandom_range(0, 1)) write_reg(REG_CODED_W, pick_coded());
      if (first || $urandom_range(0, 1)) write_reg(REG_CODED_H, pick_coded());
      ecw = clamp_span(geo_cw, 2, 4096);
      ech = clamp_span(geo_ch, 2, 4096);
      if (first || $urandom_range(0, 1)) write_reg(REG_VIS_W, pick_visible(ecw));
      if (first || $urandom_range(0, 1)) write_reg(REG_VIS_H, pick_visible(ech));
      first = 1'b0;
      n = coded_bytes();
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        if (n <= 150) begin
          case ($urandom_range(0, 19))
            0, 1, 2: len = $urandom_range(1, n - 1);
            3, 4, 5: len = n + $urandom_range(1, 6);
            default: len = n;
          endcase
        end else begin
          len = $urandom_range(1, 40);
        end
        queue_bytes(len, 1'b1, sent);
      end
      // Noise with scattered frame ends
      if ($urandom_range(0, 5) == 0) begin
        for (int i = $urandom_range(1, 12); i > 0; i--) begin
          nb.data = 8'($urandom_range(0, 255));
          nb.last = ($urandom_range(0, 9) == 0);
          nv12_bytes_q.push_back(nb);
          sent++;
        end
      end
      // Leave a frame open so the next geometry lands mid-frame
      if ($urandom_range(0, 3) == 0)
        queue_bytes($urandom_range(1, (n > 40) ? 40 : n - 1), 1'b0, sent);
    end

    // Closing stretch with no idling on either side
    settle();
    idle_odds = 0;
    write_reg(REG_CODED_W, 13'd6);
    write_reg(REG_CODED_H, 13'd4);
    write_reg(REG_VIS_W, 13'd5);
    write_reg(REG_VIS_H, 13'd4);
    queue_bytes(36, 1'b1, sent);
    queue_bytes(36, 1'b1, sent);
    settle();

    if (i420_writes_q.size() != 0) begin
      $display("%0t ns: %0d expected results, got none of them", $time, i420_writes_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/n2i_pkg.sv
rtl/core/n2i_front.sv
rtl/core/n2i_queue.sv
rtl/core/n2i_back.sv
rtl/core/nv12_to_i420_crop_unit.sv
rtl/core/n2i_checker.sv
tb/sv/tb.sv
